### hdl/slpa_pkg.sv
// ----------------------------------------------------------------------------
// slpa_pkg
// Constants and widths shared by the sensor line to percent averager.
// ----------------------------------------------------------------------------
package slpa_pkg;

    // ring and line sizes
    localparam int RING_DEPTH  = 5;
    localparam int MAX_DIGITS  = 5;
    localparam int RING_IDX_W  = $clog2(RING_DEPTH);
    localparam int COUNT_W     = 3;

    // field widths
    localparam int CHAR_W      = 8;
    localparam int RES_W       = 14;
    localparam int ACC_W       = 17;
    localparam int PCT_W       = 7;

    // shared divider: quotient bits, divisor shifted up by QUOT_W-1
    localparam int QUOT_W      = PCT_W;
    localparam int DIV_W       = RES_W + QUOT_W - 1;
    localparam int PROD_W      = RES_W + PCT_W;
    localparam int DIV_CNT_W   = $clog2(QUOT_W);
    localparam int SUM_W       = $clog2(RING_DEPTH * 100 + 1);

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EMPTY = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FULL  = 1'b1;

    // constants
    localparam logic [CHAR_W-1:0] CHAR_CR       = 8'h0d;
    localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE     = 8'h39;
    localparam logic [ACC_W-1:0]  READING_LIMIT = 17'd10000;
    localparam logic [RES_W-1:0]  FULL_RES_INIT = 14'd10000;
    localparam logic [PCT_W-1:0]  FULL_SCALE    = 7'd100;
    localparam logic [PCT_W-1:0]  LOW_THRESHOLD = 7'd10;

endpackage

### hdl/sensor_line_to_percent_averager.sv
// ----------------------------------------------------------------------------
// sensor_line_to_percent_averager
// Builds resistance readings from ASCII digits, scales each line to a
// percent level and keeps a ring of levels with average, minimum and maximum.
// ----------------------------------------------------------------------------
// One result item per input character. A character other than a carriage
// return, or a carriage return ending a rejected line, goes from idle straight
// to the finish state. An accepted line's carriage return runs one shared
// restoring divider, one quotient bit per cycle, for the level (unless it is
// clamped to 0 or 100), sweeps the ring one entry per cycle for sum, minimum
// and maximum, and forms the floor average with the same divider. A new item
// is accepted only while the sequencer is idle; a finished result may still
// wait in the output register meanwhile.
module sensor_line_to_percent_averager
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_write_en,
    input  logic [slpa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [slpa_pkg::RES_W-1:0]        cfg_data,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [slpa_pkg::CHAR_W-1:0]       character,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              line_done,
    output logic                              accepted,
    output logic [slpa_pkg::PCT_W-1:0]        level_percent,
    output logic                              low_level,
    output logic [slpa_pkg::PCT_W-1:0]        average_percent,
    output logic [slpa_pkg::PCT_W-1:0]        minimum_percent,
    output logic [slpa_pkg::PCT_W-1:0]        maximum_percent
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_DIVIDE,
        ST_STORE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    state_t                              state_reg, state_next;

    logic [slpa_pkg::RES_W-1:0]          empty_reg, empty_next;
    logic [slpa_pkg::RES_W-1:0]          full_reg, full_next;

    logic [slpa_pkg::ACC_W-1:0]          acc_reg, acc_next;
    logic [slpa_pkg::COUNT_W-1:0]        count_reg, count_next;
    logic                                stopped_reg, stopped_next;
    logic                                overflow_reg, overflow_next;

    logic [slpa_pkg::PCT_W-1:0]          ring_reg [slpa_pkg::RING_DEPTH];
    logic [slpa_pkg::PCT_W-1:0]          ring_next [slpa_pkg::RING_DEPTH];
    logic [slpa_pkg::RING_IDX_W-1:0]     wpos_reg, wpos_next;
    logic [slpa_pkg::RING_IDX_W-1:0]     idx_reg, idx_next;
    logic [slpa_pkg::PCT_W-1:0]          last_reg, last_next;

    logic [slpa_pkg::SUM_W-1:0]          sum_reg, sum_next;
    logic [slpa_pkg::PCT_W-1:0]          min_reg, min_next;
    logic [slpa_pkg::PCT_W-1:0]          max_reg, max_next;
    logic [slpa_pkg::PCT_W-1:0]          avg_reg, avg_next;

    logic [slpa_pkg::DIV_W-1:0]          num_reg, num_next;
    logic [slpa_pkg::DIV_W-1:0]          den_reg, den_next;
    logic [slpa_pkg::QUOT_W-1:0]         quot_reg, quot_next;
    logic [slpa_pkg::DIV_CNT_W-1:0]      dcnt_reg, dcnt_next;
    logic                                div_avg_reg, div_avg_next;

    logic                                done_reg, done_next;
    logic                                acc_ok_reg, acc_ok_next;

    logic                                out_valid_reg, out_valid_next;
    logic                                o_done_reg, o_done_next;
    logic                                o_acc_reg, o_acc_next;
    logic [slpa_pkg::PCT_W-1:0]          o_level_reg, o_level_next;
    logic                                o_low_reg, o_low_next;
    logic [slpa_pkg::PCT_W-1:0]          o_avg_reg, o_avg_next;
    logic [slpa_pkg::PCT_W-1:0]          o_min_reg, o_min_next;
    logic [slpa_pkg::PCT_W-1:0]          o_max_reg, o_max_next;

    logic                                in_accept;
    logic                                line_ok;
    logic [slpa_pkg::RES_W-1:0]          span;
    logic [slpa_pkg::RES_W-1:0]          offset;
    logic [slpa_pkg::PROD_W-1:0]         product;
    logic [slpa_pkg::ACC_W-1:0]          acc_times_ten;
    logic [slpa_pkg::DIV_W:0]            diff;
    logic [slpa_pkg::QUOT_W-1:0]         quot_step;
    logic [slpa_pkg::PCT_W-1:0]          entry;
    logic [slpa_pkg::SUM_W-1:0]          sum_step;
    logic                                sweep_last;

    assign in_accept = in_valid && (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE);

    assign line_ok = !overflow_reg && (acc_reg < slpa_pkg::READING_LIMIT)
                     && (full_reg > empty_reg);
    assign span    = full_reg - empty_reg;
    assign offset  = acc_reg[slpa_pkg::RES_W-1:0] - empty_reg;
    assign product = slpa_pkg::PROD_W'(offset) * slpa_pkg::PROD_W'(slpa_pkg::FULL_SCALE);
    assign acc_times_ten = (acc_reg << 3) + (acc_reg << 1);

    // shared restoring divider step
    assign diff      = {1'b0, num_reg} - {1'b0, den_reg};
    assign quot_step = {quot_reg[slpa_pkg::QUOT_W-2:0], ~diff[slpa_pkg::DIV_W]};

    assign entry      = ring_reg[idx_reg];
    assign sum_step   = (idx_reg == '0) ? slpa_pkg::SUM_W'(entry)
                                        : sum_reg + slpa_pkg::SUM_W'(entry);
    assign sweep_last = (idx_reg == slpa_pkg::RING_IDX_W'(slpa_pkg::RING_DEPTH - 1));

    always_comb
    begin
        state_next     = state_reg;
        empty_next     = empty_reg;
        full_next      = full_reg;
        acc_next       = acc_reg;
        count_next     = count_reg;
        stopped_next   = stopped_reg;
        overflow_next  = overflow_reg;
        ring_next      = ring_reg;
        wpos_next      = wpos_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        sum_next       = sum_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        avg_next       = avg_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        quot_next      = quot_reg;
        dcnt_next      = dcnt_reg;
        div_avg_next   = div_avg_reg;
        done_next      = done_reg;
        acc_ok_next    = acc_ok_reg;
        out_valid_next = out_valid_reg;
        o_done_next    = o_done_reg;
        o_acc_next     = o_acc_reg;
        o_level_next   = o_level_reg;
        o_low_next     = o_low_reg;
        o_avg_next     = o_avg_reg;
        o_min_next     = o_min_reg;
        o_max_next     = o_max_reg;

        if (cfg_write_en)
        begin
            unique case (cfg_index)
                slpa_pkg::CFG_EMPTY: empty_next = cfg_data;
                slpa_pkg::CFG_FULL:  full_next  = cfg_data;
                default:             empty_next = empty_reg;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    acc_ok_next = 1'b0;
                    if (character == slpa_pkg::CHAR_CR)
                    begin
                        done_next     = 1'b1;
                        acc_next      = '0;
                        count_next    = '0;
                        stopped_next  = 1'b0;
                        overflow_next = 1'b0;
                        state_next    = ST_FINISH;
                        if (line_ok)
                        begin
                            acc_ok_next = 1'b1;
                            if (acc_reg <= slpa_pkg::ACC_W'(empty_reg))
                            begin
                                quot_next  = '0;
                                state_next = ST_STORE;
                            end
                            else if (acc_reg >= slpa_pkg::ACC_W'(full_reg))
                            begin
                                quot_next  = slpa_pkg::FULL_SCALE;
                                state_next = ST_STORE;
                            end
                            else
                            begin
                                num_next     = product[slpa_pkg::DIV_W-1:0];
                                den_next     = slpa_pkg::DIV_W'(span) << (slpa_pkg::QUOT_W - 1);
                                quot_next    = '0;
                                dcnt_next    = '0;
                                div_avg_next = 1'b0;
                                state_next   = ST_DIVIDE;
                            end
                        end
                    end
                    else
                    begin
                        done_next  = 1'b0;
                        state_next = ST_FINISH;
                        if (count_reg >= slpa_pkg::COUNT_W'(slpa_pkg::MAX_DIGITS))
                        begin
                            overflow_next = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                            if ((character >= slpa_pkg::CHAR_ZERO) &&
                                (character <= slpa_pkg::CHAR_NINE) && !stopped_reg)
                            begin
                                acc_next = acc_times_ten
                                           + slpa_pkg::ACC_W'(character - slpa_pkg::CHAR_ZERO);
                            end
                            else
                            begin
                                stopped_next = 1'b1;
                            end
                        end
                    end
                end
            end

            ST_DIVIDE:
            begin
                if (!diff[slpa_pkg::DIV_W])
                begin
                    num_next = diff[slpa_pkg::DIV_W-1:0];
                end
                quot_next = quot_step;
                den_next  = den_reg >> 1;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == slpa_pkg::DIV_CNT_W'(slpa_pkg::QUOT_W - 1))
                begin
                    if (div_avg_reg)
                    begin
                        avg_next   = quot_step;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_STORE;
                    end
                end
            end

            ST_STORE:
            begin
                ring_next[wpos_reg] = quot_reg;
                last_next           = quot_reg;
                if (wpos_reg == slpa_pkg::RING_IDX_W'(slpa_pkg::RING_DEPTH - 1))
                begin
                    wpos_next = '0;
                end
                else
                begin
                    wpos_next = wpos_reg + 1'b1;
                end
                idx_next   = '0;
                state_next = ST_SWEEP;
            end

            ST_SWEEP:
            begin
                sum_next = sum_step;
                if (idx_reg == '0)
                begin
                    min_next = entry;
                    max_next = entry;
                end
                else
                begin
                    if (entry < min_reg)
                    begin
                        min_next = entry;
                    end
                    if (entry > max_reg)
                    begin
                        max_next = entry;
                    end
                end
                if (sweep_last)
                begin
                    num_next     = slpa_pkg::DIV_W'(sum_step);
                    den_next     = slpa_pkg::DIV_W'(slpa_pkg::RING_DEPTH) << (slpa_pkg::QUOT_W - 1);
                    quot_next    = '0;
                    dcnt_next    = '0;
                    div_avg_next = 1'b1;
                    state_next   = ST_DIVIDE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    o_done_next    = done_reg;
                    o_acc_next     = acc_ok_reg;
                    o_level_next   = last_reg;
                    o_low_next     = (last_reg < slpa_pkg::LOW_THRESHOLD);
                    o_avg_next     = avg_reg;
                    o_min_next     = min_reg;
                    o_max_next     = max_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            empty_reg     <= '0;
            full_reg      <= slpa_pkg::FULL_RES_INIT;
            acc_reg       <= '0;
            count_reg     <= '0;
            stopped_reg   <= 1'b0;
            overflow_reg  <= 1'b0;
            for (int i = 0; i < slpa_pkg::RING_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
            wpos_reg      <= '0;
            idx_reg       <= '0;
            last_reg      <= '0;
            sum_reg       <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            avg_reg       <= '0;
            num_reg       <= '0;
            den_reg       <= '0;
            quot_reg      <= '0;
            dcnt_reg      <= '0;
            div_avg_reg   <= 1'b0;
            done_reg      <= 1'b0;
            acc_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            o_done_reg    <= 1'b0;
            o_acc_reg     <= 1'b0;
            o_level_reg   <= '0;
            o_low_reg     <= 1'b0;
            o_avg_reg     <= '0;
            o_min_reg     <= '0;
            o_max_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            empty_reg     <= empty_next;
            full_reg      <= full_next;
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            stopped_reg   <= stopped_next;
            overflow_reg  <= overflow_next;
            ring_reg      <= ring_next;
            wpos_reg      <= wpos_next;
            idx_reg       <= idx_next;
            last_reg      <= last_next;
            sum_reg       <= sum_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            avg_reg       <= avg_next;
            num_reg       <= num_next;
            den_reg       <= den_next;
            quot_reg      <= quot_next;
            dcnt_reg      <= dcnt_next;
            div_avg_reg   <= div_avg_next;
            done_reg      <= done_next;
            acc_ok_reg    <= acc_ok_next;
            out_valid_reg <= out_valid_next;
            o_done_reg    <= o_done_next;
            o_acc_reg     <= o_acc_next;
            o_level_reg   <= o_level_next;
            o_low_reg     <= o_low_next;
            o_avg_reg     <= o_avg_next;
            o_min_reg     <= o_min_next;
            o_max_reg     <= o_max_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign line_done       = o_done_reg;
    assign accepted        = o_acc_reg;
    assign level_percent   = o_level_reg;
    assign low_level       = o_low_reg;
    assign average_percent = o_avg_reg;
    assign minimum_percent = o_min_reg;
    assign maximum_percent = o_max_reg;

endmodule

### verif/sensor_line_to_percent_averager_tb.sv
// ----------------------------------------------------------------------------
// sensor_line_to_percent_averager_tb
// Sends ASCII sensor lines through the averager under several calibration
// settings and checks every result item against a cycle-free model of the
// line parser, percent scaling and level ring, with random idling on both
// channels and a long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module sensor_line_to_percent_averager_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int END_SETTLE   = 40;
    localparam int LINE_ITEMS   = 120;
    localparam int BAD_CAL_ITEMS = 40;

    typedef struct packed {
        logic                       line_done;
        logic                       accepted;
        logic [slpa_pkg::PCT_W-1:0] level;
        logic                       low;
        logic [slpa_pkg::PCT_W-1:0] average;
        logic [slpa_pkg::PCT_W-1:0] min_pct;
        logic [slpa_pkg::PCT_W-1:0] max_pct;
    } level_report_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_write_en = 1'b0;
    logic [slpa_pkg::CFG_INDEX_W-1:0] cfg_index = slpa_pkg::CFG_EMPTY;
    logic [slpa_pkg::RES_W-1:0]       cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic [slpa_pkg::CHAR_W-1:0]      character = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic                             line_done;
    logic                             accepted;
    logic [slpa_pkg::PCT_W-1:0]       level_percent;
    logic                             low_level;
    logic [slpa_pkg::PCT_W-1:0]       average_percent;
    logic [slpa_pkg::PCT_W-1:0]       minimum_percent;
    logic [slpa_pkg::PCT_W-1:0]       maximum_percent;

    // calibration and line state of the model
    logic [slpa_pkg::RES_W-1:0]   empty_setting = '0;
    logic [slpa_pkg::RES_W-1:0]   full_setting = slpa_pkg::FULL_RES_INIT;
    logic [slpa_pkg::ACC_W-1:0]   reading = '0;
    logic [slpa_pkg::COUNT_W-1:0] bytes_on_line = '0;
    logic                         number_stopped = 1'b0;
    logic                         line_too_long = 1'b0;
    logic [slpa_pkg::PCT_W-1:0]   level_ring [slpa_pkg::RING_DEPTH];
    int                           ring_pos = 0;
    logic [slpa_pkg::PCT_W-1:0]   last_level = '0;

    logic [slpa_pkg::CHAR_W-1:0] pending_chars [$];
    level_report_t     expected_reports [$];
    level_report_t     oldest_report;
    int                chars_offered = 0;
    int                chars_accepted = 0;
    int                mismatch_count = 0;
    int                cycle_count = 0;
    int unsigned       send_idle_pct = 26;
    int unsigned       recv_idle_pct = 70;
    int                hold_trigger = 0;
    int                hold_seen = 0;
    int                hold_left = 0;

    sensor_line_to_percent_averager i_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .character       (character),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .line_done       (line_done),
        .accepted        (accepted),
        .level_percent   (level_percent),
        .low_level       (low_level),
        .average_percent (average_percent),
        .minimum_percent (minimum_percent),
        .maximum_percent (maximum_percent)
    );

    initial
    begin
        for (int i = 0; i < slpa_pkg::RING_DEPTH; i++)
        begin
            level_ring[i] = '0;
        end
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic level_report_t predict_level_report(
        input logic [slpa_pkg::CHAR_W-1:0] ch);
        level_report_t rpt;
        int unsigned   r;
        int unsigned   emp;
        int unsigned   ful;
        int unsigned   sum;
        rpt = '0;
        emp = empty_setting;
        ful = full_setting;
        if (ch == slpa_pkg::CHAR_CR)
        begin
            rpt.line_done = 1'b1;
            if (!line_too_long && reading < slpa_pkg::READING_LIMIT && ful > emp)
            begin
                r = reading;
                if (r <= emp)
                    last_level = '0;
                else if (r >= ful)
                    last_level = slpa_pkg::FULL_SCALE;
                else
                    last_level = slpa_pkg::PCT_W'((100 * (r - emp)) / (ful - emp));
                level_ring[ring_pos] = last_level;
                ring_pos = (ring_pos == slpa_pkg::RING_DEPTH - 1) ? 0 : ring_pos + 1;
                rpt.accepted = 1'b1;
            end
            reading = '0;
            bytes_on_line = '0;
            number_stopped = 1'b0;
            line_too_long = 1'b0;
        end
        else if (bytes_on_line >= slpa_pkg::MAX_DIGITS)
        begin
            line_too_long = 1'b1;
        end
        else
        begin
            bytes_on_line++;
            if (ch >= slpa_pkg::CHAR_ZERO && ch <= slpa_pkg::CHAR_NINE && !number_stopped)
                reading = slpa_pkg::ACC_W'(reading * 10 + (ch - slpa_pkg::CHAR_ZERO));
            else
                number_stopped = 1'b1;
        end
        sum = 0;
        rpt.min_pct = level_ring[0];
        rpt.max_pct = level_ring[0];
        for (int i = 0; i < slpa_pkg::RING_DEPTH; i++)
        begin
            sum += level_ring[i];
            if (level_ring[i] < rpt.min_pct)
                rpt.min_pct = level_ring[i];
            if (level_ring[i] > rpt.max_pct)
                rpt.max_pct = level_ring[i];
        end
        rpt.level = last_level;
        rpt.low = (last_level < slpa_pkg::LOW_THRESHOLD);
        rpt.average = slpa_pkg::PCT_W'(sum / slpa_pkg::RING_DEPTH);
        return rpt;
    endfunction

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // character driver
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && chars_accepted != chars_offered))
        begin
            if (pending_chars.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                character <= pending_chars.pop_front();
                in_valid <= 1'b1;
                chars_offered++;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_seen != hold_trigger)
        begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: unexpected result item, expected none actual level %0d",
                             $time, level_percent);
                    mismatch_count++;
                end
                else
                begin
                    oldest_report = expected_reports.pop_front();
                    compare_field("line_done", oldest_report.line_done, line_done);
                    compare_field("accepted", oldest_report.accepted, accepted);
                    compare_field("level_percent", oldest_report.level, level_percent);
                    compare_field("low_level", oldest_report.low, low_level);
                    compare_field("average_percent", oldest_report.average, average_percent);
                    compare_field("minimum_percent", oldest_report.min_pct, minimum_percent);
                    compare_field("maximum_percent", oldest_report.max_pct, maximum_percent);
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_reports.push_back(predict_level_report(character));
                chars_accepted++;
            end
        end
    end

    task automatic wait_for_drain();
        while (pending_chars.size() != 0 || chars_accepted != chars_offered ||
               expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_register(input logic [slpa_pkg::CFG_INDEX_W-1:0] idx,
                                  input int unsigned value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= slpa_pkg::RES_W'(value);
        if (idx == slpa_pkg::CFG_EMPTY)
            empty_setting = slpa_pkg::RES_W'(value);
        else
            full_setting = slpa_pkg::RES_W'(value);
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic push_line_text(input string text);
        for (int i = 0; i < text.len(); i++)
        begin
            pending_chars.push_back(text[i]);
        end
        pending_chars.push_back(slpa_pkg::CHAR_CR);
    endtask

    // pushes the lowest width decimal digits of value, most significant first
    task automatic push_digits(input int unsigned value, input int unsigned width,
                               inout int added);
        int unsigned scale;
        scale = 1;
        for (int i = 1; i < width; i++)
        begin
            scale *= 10;
        end
        for (int i = 0; i < width; i++)
        begin
            pending_chars.push_back(slpa_pkg::CHAR_ZERO
                                    + slpa_pkg::CHAR_W'((value / scale) % 10));
            scale /= 10;
            added++;
        end
    endtask

    function automatic int unsigned near_reading(input int unsigned base);
        int v;
        v = int'(base) + int'($urandom_range(40)) - 20;
        if (v < 0)
            v = 0;
        if (v > 9999)
            v = 9999;
        return unsigned'(v);
    endfunction

    task automatic run_phase(input int unsigned empty_res, input int unsigned full_res,
                             input int count, input int unsigned send_idle,
                             input int unsigned recv_idle, input bit long_hold);
        int          added;
        int unsigned kind;
        int unsigned value;
        int unsigned width;
        int unsigned b;
        added = 0;
        write_register(slpa_pkg::CFG_EMPTY, empty_res);
        write_register(slpa_pkg::CFG_FULL, full_res);
        send_idle_pct = send_idle;
        recv_idle_pct = recv_idle;
        if (long_hold)
            hold_trigger++;
        while (added < count)
        begin
            kind = $urandom_range(99);
            if (kind < 70)
            begin
                case ($urandom_range(3))
                    0: value = near_reading(empty_setting);
                    1: value = near_reading(full_setting);
                    2: value = $urandom_range(9999);
                    default: value = $urandom_range(20);
                endcase
                width = 1;
                while (width < slpa_pkg::MAX_DIGITS && value >= 10 ** width)
                begin
                    width++;
                end
                if ($urandom_range(3) == 0)
                    width = $urandom_range(slpa_pkg::MAX_DIGITS, width);
                if (value == 0 && $urandom_range(1) == 1)
                    width = 0;
                push_digits(value, width, added);
            end
            else if (kind < 78)
            begin
                push_digits($urandom_range(99999, 10000), slpa_pkg::MAX_DIGITS, added);
            end
            else if (kind < 86)
            begin
                push_digits($urandom_range(99999), slpa_pkg::MAX_DIGITS, added);
                push_digits($urandom_range(9999), $urandom_range(4, 1), added);
            end
            else if (kind < 93)
            begin
                push_digits($urandom_range(99), $urandom_range(2), added);
                do
                    b = $urandom_range(255);
                while ((b >= slpa_pkg::CHAR_ZERO && b <= slpa_pkg::CHAR_NINE) ||
                       b == slpa_pkg::CHAR_CR);
                pending_chars.push_back(slpa_pkg::CHAR_W'(b));
                added++;
                push_digits($urandom_range(99), $urandom_range(2), added);
            end
            else
            begin
                repeat ($urandom_range(8, 1))
                begin
                    pending_chars.push_back(slpa_pkg::CHAR_W'($urandom_range(255)));
                    added++;
                end
            end
            if (kind < 93)
            begin
                pending_chars.push_back(slpa_pkg::CHAR_CR);
                added++;
            end
        end
        wait_for_drain();
    endtask

    initial
    begin
        int unsigned e;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // directed lines at the reset calibration
        push_line_text("");
        push_line_text("9999");
        push_line_text("10000");
        push_line_text("123456");
        push_line_text("12a3");
        pending_chars.push_back(8'hff);
        pending_chars.push_back(8'h00);
        pending_chars.push_back(slpa_pkg::CHAR_CR);
        wait_for_drain();

        run_phase(0, 10000, LINE_ITEMS, 26, 70, 1'b0);
        run_phase(9999, 10000, LINE_ITEMS, 26, 70, 1'b0);
        e = $urandom_range(4999);
        run_phase(e, $urandom_range(10000, e + 1), LINE_ITEMS, 70, 26, 1'b0);
        run_phase(5000, 5000, BAD_CAL_ITEMS, 70, 26, 1'b0);
        run_phase(9999, 0, BAD_CAL_ITEMS, 70, 26, 1'b0);
        run_phase(8191, 9999, LINE_ITEMS, 0, 0, 1'b1);
        e = $urandom_range(9999);
        run_phase(e, $urandom_range(10000, e + 1), LINE_ITEMS, 0, 0, 1'b0);
        run_phase(0, 1, LINE_ITEMS, 0, 0, 1'b0);

        repeat (END_SETTLE) @(posedge clk);
        if (expected_reports.size() != 0)
        begin
            $display("%0t: results missing, expected %0d more actual 0",
                     $time, expected_reports.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
